[rtl/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, character codes and helpers for the format spec parser.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned StarW  = 32;
  localparam int unsigned FwW    = 31;
  localparam int unsigned PrecW  = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  localparam logic [FwW-1:0] SatMax = {FwW{1'b1}};

  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChHash  = 8'h23;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChStar  = 8'h2A;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChLc    = 8'h63;
  localparam logic [ByteW-1:0] ChLs    = 8'h73;
  localparam logic [ByteW-1:0] ChLp    = 8'h70;
  localparam logic [ByteW-1:0] ChLd    = 8'h64;
  localparam logic [ByteW-1:0] ChLi    = 8'h69;
  localparam logic [ByteW-1:0] ChLu    = 8'h75;
  localparam logic [ByteW-1:0] ChLx    = 8'h78;
  localparam logic [ByteW-1:0] ChUx    = 8'h58;
  localparam logic [ByteW-1:0] ChPct   = 8'h25;

  typedef struct packed {
    logic              plus;
    logic              space;
    logic              alt;
    logic              zero;
    logic              left;
  } pfs_flags_t;

  typedef struct packed {
    logic              bad_conversion;
    logic [ByteW-1:0]  conversion;
    logic [PrecW-1:0]  precision_value;
    logic [FwW-1:0]    field_width;
    logic              force_sign;
    logic              blank_sign;
    logic              hash_alt;
    logic              pad_zero;
    logic              left_just;
  } pfs_result_t;

  function automatic logic is_conv(input logic [ByteW-1:0] b);
    logic r;
    case (b) inside
      ChLc, ChLs, ChLp, ChLd, ChLi, ChLu, ChLx, ChUx, ChPct: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  // acc * 10 + digit, saturating
  function automatic logic [FwW-1:0] dec_acc(input logic [FwW-1:0] acc,
                                             input logic [ByteW-1:0] b);
    logic [FwW+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(FwW){1'b0}}, b[3:0]};
    return (v > {4'b0000, SatMax}) ? SatMax : v[FwW-1:0];
  endfunction

endpackage

[rtl/pfs_parse.sv]
// ----------------------------------------------------------------------------
// pfs_parse
// Phase register, flag bits and width/precision accumulators; forms a result
// word at the conversion byte.
// ----------------------------------------------------------------------------
module pfs_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [pfs_pkg::ByteW-1:0] spec_byte,
  input  logic [pfs_pkg::StarW-1:0] star_value,
  output logic                      res_valid,
  output pfs_pkg::pfs_result_t      res
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    PH_FLAGS, PH_WDIGITS, PH_AFTER_W, PH_PSTART, PH_PDIGITS, PH_AFTER_P
  } phase_t;

  phase_t           phase, phase_next;
  pfs_flags_t       flag_bits, flag_bits_next;
  logic [FwW-1:0]   width_acc, width_acc_next;
  logic [PrecW-1:0] precision_acc, precision_acc_next;
  logic             finish;

  logic             neg;
  logic [StarW-1:0] mag;
  logic [FwW-1:0]   star_w;
  logic             flag_hit;
  pfs_flags_t       flag_set;

  assign neg    = star_value[StarW-1];
  assign mag    = neg ? (~star_value + StarW'(1)) : star_value;
  assign star_w = mag[StarW-1] ? SatMax : mag[FwW-1:0];

  always_comb begin
    flag_set = '0;
    unique case (spec_byte)
      ChMinus: flag_set.left  = 1'b1;
      ChZero:  flag_set.zero  = 1'b1;
      ChHash:  flag_set.alt   = 1'b1;
      ChSpace: flag_set.space = 1'b1;
      ChPlus:  flag_set.plus  = 1'b1;
      default: flag_set = '0;
    endcase
    flag_hit = |flag_set;
  end

  always_comb begin
    phase_next         = phase;
    flag_bits_next     = flag_bits;
    width_acc_next     = width_acc;
    precision_acc_next = precision_acc;
    finish             = 1'b0;
    unique case (phase)
      PH_FLAGS: begin
        if (flag_hit) begin
          flag_bits_next = flag_bits | flag_set;
        end else if (spec_byte == ChStar) begin
          flag_bits_next.left = flag_bits.left | neg;
          width_acc_next      = star_w;
          phase_next          = PH_AFTER_W;
        end else if (is_digit(spec_byte)) begin
          width_acc_next = dec_acc('0, spec_byte);
          phase_next     = PH_WDIGITS;
        end else if (spec_byte == ChDot) begin
          precision_acc_next = '0;
          phase_next         = PH_PSTART;
        end else begin
          finish = 1'b1;
        end
      end
      PH_WDIGITS: begin
        if (is_digit(spec_byte)) begin
          width_acc_next = dec_acc(width_acc, spec_byte);
        end else if (spec_byte == ChDot) begin
          precision_acc_next = '0;
          phase_next         = PH_PSTART;
        end else begin
          finish = 1'b1;
        end
      end
      PH_AFTER_W: begin
        if (spec_byte == ChDot) begin
          precision_acc_next = '0;
          phase_next         = PH_PSTART;
        end else begin
          finish = 1'b1;
        end
      end
      PH_PSTART: begin
        if (spec_byte == ChStar) begin
          precision_acc_next = neg ? '1 : star_value;
          phase_next         = PH_AFTER_P;
        end else if (is_digit(spec_byte)) begin
          precision_acc_next = {1'b0, dec_acc('0, spec_byte)};
          phase_next         = PH_PDIGITS;
        end else begin
          finish = 1'b1;
        end
      end
      PH_PDIGITS: begin
        if (is_digit(spec_byte)) begin
          precision_acc_next = {1'b0, dec_acc(precision_acc[FwW-1:0], spec_byte)};
        end else begin
          finish = 1'b1;
        end
      end
      PH_AFTER_P: finish = 1'b1;
      default:    finish = 1'b1;
    endcase
    if (finish) begin
      phase_next         = PH_FLAGS;
      flag_bits_next     = '0;
      width_acc_next     = '0;
      precision_acc_next = '1;
    end
  end

  always_comb begin
    res_valid           = accept & finish;
    res.left_just       = flag_bits.left;
    res.pad_zero        = flag_bits.zero & ~flag_bits.left & (&precision_acc);
    res.hash_alt        = flag_bits.alt;
    res.blank_sign      = flag_bits.space & ~flag_bits.plus;
    res.force_sign      = flag_bits.plus;
    res.field_width     = width_acc;
    res.precision_value = precision_acc;
    res.conversion      = spec_byte;
    res.bad_conversion  = ~is_conv(spec_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FLAGS;
      flag_bits     <= '0;
      width_acc     <= '0;
      precision_acc <= '1;
    end else if (accept) begin
      phase         <= phase_next;
      flag_bits     <= flag_bits_next;
      width_acc     <= width_acc_next;
      precision_acc <= precision_acc_next;
    end
  end

endmodule

[rtl/pfs_out_buf.sv]
// ----------------------------------------------------------------------------
// pfs_out_buf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module pfs_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  pfs_pkg::pfs_result_t in_res,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfs_pkg::pfs_result_t out_res
);
  import pfs_pkg::*;

  logic        skid_valid;
  pfs_result_t skid_res;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

endmodule

[rtl/printf_format_spec_parser.sv]
// ----------------------------------------------------------------------------
// printf_format_spec_parser
// Parses a printf conversion spec one byte per word.
//
// Slave channel: one word per byte following '%', with the star argument
// alongside. Master channel: one word per finished spec, at the conversion
// byte; tuser flags an invalid conversion byte. Flag, width and precision
// bytes produce no output word.
// Throughput: one input word per cycle while s_tready is high. The parse state
// updates in the cycle the word is taken; the output buffer registers the result for m_tvalid.
// Reset (rst, synchronous, active high) returns the parser to the flags
// phase and empties the output buffer.
// When the receiver stalls, a two-entry output buffer absorbs one more
// result; s_tready falls only once both entries hold results.
// ----------------------------------------------------------------------------
module printf_format_spec_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pfs_pkg::InDataW-1:0]  s_tdata,   // spec_byte, star_value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pfs_pkg::OutDataW-1:0] m_tdata,   // left_just, pad_zero,
                                                  // hash_alt, blank_sign,
                                                  // force_sign, field_width,
                                                  // precision_value,
                                                  // conversion, zero fill
  output logic                         m_tuser    // bad_conversion
);
  import pfs_pkg::*;

  logic        accept;
  logic        res_valid;
  pfs_result_t res, out_res;

  assign accept = s_tvalid & s_tready;

  pfs_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .spec_byte  (s_tdata[ByteW-1:0]),
    .star_value (s_tdata[ByteW+StarW-1:ByteW]),
    .res_valid  (res_valid),
    .res        (res)
  );

  pfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {4'b0000, out_res.conversion, out_res.precision_value,
                    out_res.field_width, out_res.force_sign, out_res.blank_sign,
                    out_res.hash_alt, out_res.pad_zero, out_res.left_just};
  assign m_tuser = out_res.bad_conversion;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for printf_format_spec_parser. A clocked driver feeds
// spec bytes from a queue in random bursts; each accepted word runs through
// a local parser model that queues the expected result word. A clocked
// monitor stalls m_tready on its own pattern, including one long hold, and
// checks every output word field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import pfs_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 300;

  typedef enum logic [2:0] {
    SP_FLAGS, SP_WDIGITS, SP_AFTER_W, SP_PSTART, SP_PDIGITS, SP_AFTER_P
  } spec_phase_t;

  typedef struct {
    logic [ByteW-1:0] ch;
    logic [StarW-1:0] star;
    logic             drain;
  } spec_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  spec_word_t  spec_words[$];
  pfs_result_t expected_specs[$];
  logic        drain_armed = 1'b0;
  int          fail_count = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;

  // parser model state
  spec_phase_t      spec_phase;
  pfs_flags_t       spec_flags;
  logic [FwW-1:0]   spec_width;
  logic [PrecW-1:0] spec_prec;

  printf_format_spec_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_dec(input logic [ByteW-1:0] ch);
    return ch >= ChZero && ch <= ChNine;
  endfunction

  function automatic logic is_letter(input logic [ByteW-1:0] ch);
    logic r;
    case (ch) inside
      ChLc, ChLs, ChLp, ChLd, ChLi, ChLu, ChLx, ChUx, ChPct: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic pfs_flags_t flag_for(input logic [ByteW-1:0] ch);
    pfs_flags_t f;
    f = '0;
    case (ch)
      ChMinus: f.left = 1'b1;
      ChZero:  f.zero = 1'b1;
      ChHash:  f.alt = 1'b1;
      ChSpace: f.space = 1'b1;
      ChPlus:  f.plus = 1'b1;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [FwW-1:0] times_ten_plus(input logic [FwW-1:0] acc,
                                                    input logic [ByteW-1:0] ch);
    logic [FwW+3:0] v;
    v = (FwW+4)'(acc) * (FwW+4)'(10) + (FwW+4)'(ch - ChZero);
    return (v > (FwW+4)'(SatMax)) ? SatMax : v[FwW-1:0];
  endfunction

  task automatic clear_spec();
    spec_phase = SP_FLAGS;
    spec_flags = '0;
    spec_width = '0;
    spec_prec  = '1;
  endtask

  task automatic close_spec(input logic [ByteW-1:0] ch);
    pfs_result_t r;
    r.left_just       = spec_flags.left;
    r.force_sign      = spec_flags.plus;
    r.pad_zero        = spec_flags.zero && !spec_flags.left && (spec_prec == '1);
    r.blank_sign      = spec_flags.space && !spec_flags.plus;
    r.hash_alt        = spec_flags.alt;
    r.field_width     = spec_width;
    r.precision_value = spec_prec;
    r.conversion      = ch;
    r.bad_conversion  = !is_letter(ch);
    expected_specs.push_back(r);
    clear_spec();
  endtask

  task automatic parse_spec_byte(input logic [ByteW-1:0] ch, input logic [StarW-1:0] star);
    logic [StarW-1:0] mag;
    pfs_flags_t       f;
    mag = star[StarW-1] ? -star : star;
    f = flag_for(ch);
    case (spec_phase)
      SP_FLAGS: begin
        if (f != '0) begin
          spec_flags = spec_flags | f;
        end else if (ch == ChStar) begin
          if (star[StarW-1]) spec_flags.left = 1'b1;
          spec_width = (mag > StarW'(SatMax)) ? SatMax : mag[FwW-1:0];
          spec_phase = SP_AFTER_W;
        end else if (is_dec(ch)) begin
          spec_width = times_ten_plus('0, ch);
          spec_phase = SP_WDIGITS;
        end else if (ch == ChDot) begin
          spec_prec = '0;
          spec_phase = SP_PSTART;
        end else begin
          close_spec(ch);
        end
      end
      SP_WDIGITS: begin
        if (is_dec(ch)) begin
          spec_width = times_ten_plus(spec_width, ch);
        end else if (ch == ChDot) begin
          spec_prec = '0;
          spec_phase = SP_PSTART;
        end else begin
          close_spec(ch);
        end
      end
      SP_AFTER_W: begin
        if (ch == ChDot) begin
          spec_prec = '0;
          spec_phase = SP_PSTART;
        end else begin
          close_spec(ch);
        end
      end
      SP_PSTART: begin
        if (ch == ChStar) begin
          spec_prec = star[StarW-1] ? '1 : mag;
          spec_phase = SP_AFTER_P;
        end else if (is_dec(ch)) begin
          spec_prec = PrecW'(times_ten_plus('0, ch));
          spec_phase = SP_PDIGITS;
        end else begin
          close_spec(ch);
        end
      end
      SP_PDIGITS: begin
        if (is_dec(ch)) begin
          spec_prec = PrecW'(times_ten_plus(spec_prec[FwW-1:0], ch));
        end else begin
          close_spec(ch);
        end
      end
      default: close_spec(ch);
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    spec_word_t w;
    logic       v;
    int         burst_left;
    int         gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      clear_spec();
    end else begin
      if (s_tvalid && s_tready) parse_spec_byte(s_tdata[ByteW-1:0], s_tdata[InDataW-1:ByteW]);
      v = s_tvalid && !s_tready;
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (spec_words.size() > 0 &&
                     !(spec_words[0].drain && expected_specs.size() > 0)) begin
          w = spec_words.pop_front();
          s_tdata <= {w.star, w.ch};
          v = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
      s_tvalid <= v;
    end
  end

  // monitor
  always @(posedge clk) begin
    pfs_result_t got;
    pfs_result_t want;
    logic        r;
    int          hold_left;
    logic        hold_done;
    logic [8:0]  stall_step;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      stall_step = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = pfs_result_t'({m_tuser, m_tdata[$bits(pfs_result_t)-2:0]});
        results_seen++;
        if (m_tdata[OutDataW-1:$bits(pfs_result_t)-1] != '0) begin
          $error("fill expected 0 got %0h", m_tdata[OutDataW-1:$bits(pfs_result_t)-1]);
          fail_count++;
        end
        if (expected_specs.size() == 0) begin
          $error("result word with no spec pending: conversion %0h", got.conversion);
          fail_count++;
        end else begin
          want = expected_specs.pop_front();
          if (got.left_just !== want.left_just) begin
            $error("left_just expected %0d got %0d", want.left_just, got.left_just);
            fail_count++;
          end
          if (got.pad_zero !== want.pad_zero) begin
            $error("pad_zero expected %0d got %0d", want.pad_zero, got.pad_zero);
            fail_count++;
          end
          if (got.hash_alt !== want.hash_alt) begin
            $error("hash_alt expected %0d got %0d", want.hash_alt, got.hash_alt);
            fail_count++;
          end
          if (got.blank_sign !== want.blank_sign) begin
            $error("blank_sign expected %0d got %0d", want.blank_sign, got.blank_sign);
            fail_count++;
          end
          if (got.force_sign !== want.force_sign) begin
            $error("force_sign expected %0d got %0d", want.force_sign, got.force_sign);
            fail_count++;
          end
          if (got.field_width !== want.field_width) begin
            $error("field_width expected %0d got %0d", want.field_width, got.field_width);
            fail_count++;
          end
          if (got.precision_value !== want.precision_value) begin
            $error("precision_value expected %0d got %0d",
                   $signed(want.precision_value), $signed(got.precision_value));
            fail_count++;
          end
          if (got.conversion !== want.conversion) begin
            $error("conversion expected %0h got %0h", want.conversion, got.conversion);
            fail_count++;
          end
          if (got.bad_conversion !== want.bad_conversion) begin
            $error("bad_conversion expected %0d got %0d",
                   want.bad_conversion, got.bad_conversion);
            fail_count++;
          end
        end
      end
      stall_step++;
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = LongHold;
        r = 1'b0;
      end else begin
        case (stall_step[8:7])
          2'd0: r = 1'b1;
          2'd1: r = $urandom_range(0, 3) != 0;
          2'd2: r = 1'($urandom_range(0, 1));
          default: r = stall_step[1:0] != 2'd0;
        endcase
      end
      m_tready <= r;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_word(input logic [ByteW-1:0] ch, input logic [StarW-1:0] star);
    spec_word_t w;
    w.ch = ch;
    w.star = star;
    w.drain = drain_armed;
    drain_armed = 1'b0;
    spec_words.push_back(w);
  endtask

  function automatic logic [StarW-1:0] pick_star();
    logic [StarW-1:0] s;
    case ($urandom_range(0, 5))
      0: s = 32'h8000_0000;
      1: s = 32'h7FFF_FFFF;
      2: s = $urandom_range(0, 20);
      3: s = -StarW'($urandom_range(1, 20));
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic add_number(input logic lead_zero_ok);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && !lead_zero_ok) add_word(ChZero + ByteW'($urandom_range(1, 9)), $urandom);
      else add_word(ChZero + ByteW'($urandom_range(0, 9)), $urandom);
    end
  endtask

  task automatic add_random_spec();
    logic [ByteW-1:0] flag_chars[5];
    logic [ByteW-1:0] letters[9];
    flag_chars = '{ChMinus, ChZero, ChHash, ChSpace, ChPlus};
    letters = '{ChLc, ChLs, ChLp, ChLd, ChLi, ChLu, ChLx, ChUx, ChPct};
    repeat ($urandom_range(0, 3)) add_word(flag_chars[$urandom_range(0, 4)], $urandom);
    case ($urandom_range(0, 2))
      0: ;
      1: add_word(ChStar, pick_star());
      default: add_number(1'b0);
    endcase
    if ($urandom_range(0, 1)) begin
      add_word(ChDot, $urandom);
      case ($urandom_range(0, 2))
        0: ;
        1: add_word(ChStar, pick_star());
        default: add_number(1'b1);
      endcase
    end
    if ($urandom_range(0, 6) != 0) add_word(letters[$urandom_range(0, 8)], $urandom);
    else add_word(ByteW'($urandom_range(0, 255)), $urandom);
  endtask

  initial begin
    // directed
    add_word(ChPct, '0);
    add_word(8'h00, 32'hFFFF_FFFF);
    add_word(8'hFF, '0);
    add_word(ChStar, 32'h8000_0000);
    add_word(ChLc, '0);
    add_word(ChDot, '0);
    add_word(ChStar, -32'sd5);
    add_word(ChLs, '0);
    add_word(ChDot, '0);
    add_word(ChLp, '0);
    add_word(ChStar, 32'd7);
    add_word(ChZero + 8'd5, '0);
    add_word(ChMinus, '0);
    add_word(ChZero, '0);
    add_word(ChHash, '0);
    add_word(ChSpace, '0);
    add_word(ChPlus, '0);
    add_word(ChLi, '0);
    add_word(ChStar, 32'h7FFF_FFFF);
    add_word(ChDot, '0);
    add_word(ChStar, 32'h7FFF_FFFF);
    add_word(ChLu, '0);
    add_word(ChZero, '0);
    add_word(ChDot, '0);
    add_word(ChLx, '0);
    // random: mostly well-formed specs, some raw noise
    while (spec_words.size() < 475) begin
      if (spec_words.size() >= 260 && spec_words.size() < 300) drain_armed = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) add_word(ByteW'($urandom_range(0, 255)), $urandom);
      end else begin
        add_random_spec();
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (spec_words.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_specs.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
